>>> hdl/histogram_intersection_kernel_defines.svh
// Assertion macros shared by the histogram intersection kernel modules.
`ifndef HISTOGRAM_INTERSECTION_KERNEL_DEFINES_SVH
`define HISTOGRAM_INTERSECTION_KERNEL_DEFINES_SVH
// Concurrent assertion with synchronous reset disable.
`define HIK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Assertion that is also checked while reset is high.
`define HIK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

>>> hdl/hik_pkg.sv
// Shared types, constants and tables of the histogram intersection kernel.
package hik_pkg;
  localparam int unsigned BinW = 32;
  localparam int unsigned BetaW = 16;
  localparam int unsigned SumW = 42;
  localparam logic [15:0] BetaOne = 16'd4096;
  localparam logic [41:0] SumMax = {42{1'b1}};
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = 2;

  // One classified item passed from the front end to the power engine.
  typedef struct packed {
    logic [31:0] m;
    logic        use_power;
    logic        last;
  } hik_item_t;

  // Root table type: entry j holds S_j in unsigned Q2.31 (S_0 = 2.0).
  typedef logic [16:0][32:0] root_tab_t;

  // Root table: S_j = floor(sqrt(S_(j-1) * 2^31)), S_0 = 2^32, built at elaboration.
  function automatic root_tab_t build_roots();
    root_tab_t   tab;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    tab = '0;
    tab[0] = 33'h100000000;
    for (int j = 1; j <= 16; j++) begin
      v = {31'b0, tab[j - 1]} << 31;
      res = '0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != '0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      tab[j] = res[32:0];
    end
    return tab;
  endfunction

  localparam root_tab_t RootTab = build_roots();

  // Root table lookup.
  function automatic logic [32:0] root_val(input logic [4:0] j);
    return RootTab[j];
  endfunction
endpackage

>>> hdl/hik_front.sv
// Front end: takes bin pairs, forms the minimum and queues classified items.
`include "histogram_intersection_kernel_defines.svh"
module hik_front (
  input  logic                clk,
  input  logic                rst,
  input  logic [31:0]         a_bin,
  input  logic [31:0]         b_bin,
  input  logic                last_bin,
  input  logic                push,
  output logic                full,
  input  logic [15:0]         beta,
  output hik_pkg::hik_item_t  q_item,
  output logic                q_valid,
  input  logic                q_take
);
  hik_pkg::hik_item_t mem [hik_pkg::QDepth];
  logic [hik_pkg::QPtrW-1:0] wr_ptr;
  logic [hik_pkg::QPtrW-1:0] rd_ptr;
  logic [hik_pkg::QPtrW:0] count;
  logic [31:0] m;
  logic wr_en;
  logic rd_en;

  assign m = (a_bin < b_bin) ? a_bin : b_bin;
  assign full = (count == 3'(hik_pkg::QDepth));
  assign q_valid = (count != '0);
  assign q_item = mem[rd_ptr];
  assign wr_en = push && !full;
  assign rd_en = q_take && q_valid;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= '{m: m, use_power: (m != '0) && (beta != hik_pkg::BetaOne),
                       last: last_bin};
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      count <= count + {2'b0, wr_en} - {2'b0, rd_en};
    end
  end

  `HIK_ASSERT(a_cnt_max, count <= 3'(hik_pkg::QDepth), "queue count overflow")
  `HIK_ASSERT(a_cnt_step, (wr_en && !rd_en) |=> count == $past(count) + 1'b1, "count step")
  `HIK_ASSERT_ALWAYS(a_rst_empty, rst |=> !q_valid, "queue not empty after reset")
endmodule

>>> hdl/hik_back.sv
// Back end: sequential log2, multiply, exp2 and saturating accumulation.
`include "histogram_intersection_kernel_defines.svh"
module hik_back (
  input  logic                clk,
  input  logic                rst,
  input  hik_pkg::hik_item_t  q_item,
  input  logic                q_valid,
  output logic                q_take,
  input  logic [15:0]         beta,
  output logic [41:0]         kernel_value,
  output logic                empty,
  input  logic                pop
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StNorm = 3'd1;
  localparam logic [2:0] StLog  = 3'd2;
  localparam logic [2:0] StMul  = 3'd3;
  localparam logic [2:0] StExp  = 3'd4;
  localparam logic [2:0] StAdd  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [31:0] m;
  logic last;
  logic [4:0] msb;
  logic [32:0] y;
  logic [15:0] frac;
  logic [4:0] step;
  logic [31:0] term;
  logic signed [21:0] lg;
  logic signed [38:0] prod;
  logic signed [26:0] qv;
  logic signed [27:0] tv;
  logic [31:0] r;
  logic [15:0] f;
  logic [4:0] n;
  logic [41:0] running_sum;
  logic out_full;
  logic [42:0] sum_wide;
  logic [65:0] sq;
  logic [64:0] rm;
  logic [4:0] msb_c;
  logic [31:0] r_fin;

  assign q_take = (state == StIdle) && q_valid;
  assign empty = !out_full;
  assign sq = y * y;
  assign rm = r * hik_pkg::root_val(5'd1 + step);
  assign sum_wide = {1'b0, running_sum} + {10'b0, term};
  assign prod = lg * $signed({1'b0, beta});
  assign r_fin = f[4'd15 - step[3:0]] ? rm[62:31] : r;

  // Leading one search over the minimum.
  always_comb begin
    msb_c = '0;
    for (int i = 0; i < 32; i++) begin
      if (m[i]) msb_c = 5'(i);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      StIdle: if (q_take) state_next = q_item.use_power ? StNorm : StAdd;
      StNorm: state_next = StLog;
      StLog:  if (step == 5'd15) state_next = StMul;
      StMul:  state_next = StExp;
      StExp:  if (step == 5'd15 || tv < 0 || tv[27:16] >= 12'd32) state_next = StAdd;
      StAdd:  if (!last || !out_full) state_next = StIdle;
      default: state_next = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      StIdle: begin
        m <= q_item.m;
        last <= q_item.last;
        term <= q_item.m;
        step <= '0;
        frac <= '0;
      end
      StNorm: begin
        msb <= msb_c;
        y <= {1'b0, m << (5'd31 - msb_c)};
      end
      StLog: begin
        step <= step + 1'b1;
        if (sq[65:31] >= 35'h100000000) begin
          y <= 33'(sq[65:32]);
          frac <= {frac[14:0], 1'b1};
        end else begin
          y <= sq[63:31];
          frac <= {frac[14:0], 1'b0};
        end
        if (step == 5'd15) begin
          lg <= $signed({1'b0, msb, 16'b0}) - $signed(22'(16 << 16))
                + $signed({6'b0, frac[14:0],
                           (sq[65:31] >= 35'h100000000)});
        end
      end
      StMul: begin
        qv <= 27'(prod >>> 12);
        step <= '0;
        r <= 32'h80000000;
      end
      StExp: begin
        step <= step + 1'b1;
        r <= r_fin;
        if (tv < 0) term <= '0;
        else if (tv[27:16] >= 12'd32) term <= '1;
        else if (step == 5'd15) term <= r_fin >> (5'd31 - n);
      end
      default: ;
    endcase
  end

  assign tv = 28'(qv) + 28'sd1048576;
  assign n = tv[20:16];
  assign f = tv[15:0];

  // Accumulator and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      out_full <= 1'b0;
    end else begin
      if (pop && out_full) out_full <= 1'b0;
      if (state == StAdd && (!last || !out_full)) begin
        if (last) begin
          kernel_value <= sum_wide[42] ? hik_pkg::SumMax : sum_wide[41:0];
          out_full <= 1'b1;
          running_sum <= '0;
        end else begin
          running_sum <= sum_wide[42] ? hik_pkg::SumMax : sum_wide[41:0];
        end
      end
    end
  end

  `HIK_ASSERT(a_take_idle, q_take |-> state == StIdle, "item taken while busy")
  `HIK_ASSERT(a_out_hold, (out_full && !pop) |=> out_full && $stable(kernel_value), "result lost")
  `HIK_ASSERT(a_clear, (state == StAdd && last && !$past(out_full)) |=> running_sum == '0,
    "sum not cleared")
endmodule

>>> hdl/histogram_intersection_kernel.sv
// Top level of the generalized histogram intersection kernel.
// Bin pairs enter through a queue-style port: an item is taken when push is
// high and full is low. Each item carries a_bin, b_bin (unsigned Q16.16) and
// last_bin. The item marked last yields one kernel_value (Q26.16), the sum of
// all terms since the previous last, and the running sum then clears.
// Results leave through a queue-style port: kernel_value is valid while
// empty is low and is taken when pop is high.
// beta (Q4.12) is written through cfg_valid/cfg_ready; the user must write it
// only while the block is idle (not enforced); 4096 selects the plain minimum.
// The front end queues up to four items. The back end takes one item at a
// time and takes no new item until that one is accumulated. When beta is
// 1.0 or the minimum is zero the item goes straight to the accumulator;
// otherwise the power is computed by a 16-step squaring log2 loop, a
// multiply step and a 16-step root product exp2 loop, which stops early
// when that power underflows or saturates.
// Reset clears the queue and the sum, empties the result register and sets
// beta to 1.0. When pop stays low a finished result is held; the back end
// then stalls at the next last item and the queue fills until full rises.
module histogram_intersection_kernel (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] a_bin,
  input  logic [31:0] b_bin,
  input  logic        last_bin,
  input  logic        push,
  output logic        full,
  output logic [41:0] kernel_value,
  output logic        empty,
  input  logic        pop,
  input  logic [15:0] cfg_data,
  input  logic        cfg_valid,
  output logic        cfg_ready
);
  logic [15:0] beta;
  hik_pkg::hik_item_t q_item;
  logic q_valid;
  logic q_take;

  assign cfg_ready = 1'b1;

  // Exponent register.
  always_ff @(posedge clk) begin
    if (rst) begin
      beta <= hik_pkg::BetaOne;
    end else if (cfg_valid && cfg_ready) begin
      beta <= cfg_data;
    end
  end

  hik_front u_front (
    .clk(clk), .rst(rst), .a_bin(a_bin), .b_bin(b_bin), .last_bin(last_bin),
    .push(push), .full(full), .beta(beta), .q_item(q_item), .q_valid(q_valid),
    .q_take(q_take)
  );

  hik_back u_back (
    .clk(clk), .rst(rst), .q_item(q_item), .q_valid(q_valid), .q_take(q_take),
    .beta(beta), .kernel_value(kernel_value), .empty(empty), .pop(pop)
  );
endmodule
